/* design/bb3_pkg.sv */
package bb3_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int SAMPLE_BITS     = 16;
	localparam int COL_BITS        = $clog2(MAX_WIDTH);
	localparam int ROW_BITS        = 16;
	localparam int WCFG_BITS       = 11;
	localparam int HCFG_BITS       = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int WIN_TAPS        = 9;
	localparam int SUM_BITS        = SAMPLE_BITS + 4;
	localparam int DIV9_SHIFT      = SUM_BITS + 3;
	localparam int DIV9_MULT_BITS  = SUM_BITS;
	localparam int PROD_BITS       = SUM_BITS + DIV9_MULT_BITS;
	localparam longint DIV9_MULT   = ((64'd1 << DIV9_SHIFT) + 64'd8) / 64'd9;

	localparam logic [WCFG_BITS-1:0] WIDTH_RESET  = WCFG_BITS'(1024);
	localparam logic [HCFG_BITS-1:0] HEIGHT_RESET = HCFG_BITS'(1024);
	localparam logic [WCFG_BITS-1:0] WIDTH_MIN    = WCFG_BITS'(3);
	localparam logic [WCFG_BITS-1:0] WIDTH_MAX    = WCFG_BITS'(MAX_WIDTH);
	localparam logic [HCFG_BITS-1:0] HEIGHT_MIN   = HCFG_BITS'(3);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COL_BITS-1:0]    col_t;
	typedef logic [ROW_BITS-1:0]    row_t;
	typedef logic [SUM_BITS-1:0]    sum_t;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic emit;
		logic frame_end;
		col_t col;
	} px_ctrl_t;

endpackage

/* design/bb3_if.sv */
interface bb3_in_if;
	import bb3_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface bb3_out_if;
	import bb3_pkg::*;
	logic    valid;
	logic    ready;
	sample_t blurred;
	logic    frame_end;
	modport source (output valid, output blurred, output frame_end, input ready);
	modport sink (input valid, input blurred, input frame_end, output ready);
endinterface

interface bb3_cfg_if;
	import bb3_pkg::*;
	logic                     valid;
	logic                     ready;
	reg_index_t               index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/bb3_line_store.sv */
module bb3_line_store (
	input  logic            clk,
	input  logic            rd_en,
	input  bb3_pkg::col_t    rd_addr,
	input  bb3_pkg::sample_t sample,
	input  logic            up_wr_en,
	input  bb3_pkg::col_t    up_wr_addr,
	output bb3_pkg::sample_t top_q,
	output bb3_pkg::sample_t mid_q
);
	import bb3_pkg::*;

	sample_t upper_mem [MAX_WIDTH];
	sample_t middle_mem [MAX_WIDTH];

	// The middle row is read and overwritten with the new sample in one access.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_q <= middle_mem[rd_addr];
			middle_mem[rd_addr] <= sample;
		end
	end

	// The upper row takes the old middle value from the mid_q register when stage one advances.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_q <= upper_mem[rd_addr];
		end
		if (up_wr_en) begin
			upper_mem[up_wr_addr] <= mid_q;
		end
	end

endmodule

/* design/bb3_window_sum.sv */
module bb3_window_sum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bb3_pkg::sample_t top,
	input  bb3_pkg::sample_t mid,
	input  bb3_pkg::sample_t sample,
	output bb3_pkg::sum_t    sum_s2
);
	import bb3_pkg::*;

	sample_t win_q [WIN_TAPS];
	sample_t win_d [WIN_TAPS];
	sum_t    sum_d;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r*3 + 0] = win_q[r*3 + 1];
			win_d[r*3 + 1] = win_q[r*3 + 2];
		end
		win_d[2] = top;
		win_d[5] = mid;
		win_d[8] = sample;
		sum_d = '0;
		for (int i = 0; i < WIN_TAPS; i++) begin
			sum_d = sum_d + SUM_BITS'(win_d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (en) begin
			win_q <= win_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_d;
		end
	end

endmodule

/* design/bb3_div9.sv */
module bb3_div9 (
	input  logic             clk,
	input  logic             en,
	input  bb3_pkg::sum_t    sum,
	input  logic             frame_end,
	output bb3_pkg::sample_t blurred_q,
	output logic             frame_end_q
);
	import bb3_pkg::*;

	logic [PROD_BITS-1:0] prod;

	// Division by nine as a multiply by the rounded-up reciprocal.
	assign prod = PROD_BITS'(sum) * PROD_BITS'(DIV9_MULT[DIV9_MULT_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			blurred_q   <= prod[DIV9_SHIFT +: SAMPLE_BITS];
			frame_end_q <= frame_end;
		end
	end

endmodule

/* design/box_blur_3x3_stream_core.sv */
// Path: a result word passes the stage-one registers, the window sum register and the output
// register after the input word that completes its neighborhood is accepted.
// Throughput: one input word per cycle when the output side does not stall.
// Border pixels give no output word. Reset clears the counters, the window and the
// pipeline valid flags, and sets both frame size registers to 1024; the line stores are
// not cleared.
module box_blur_3x3_stream_core (
	input logic        clk,
	input logic        arst_n,
	bb3_in_if.sink     pix,
	bb3_out_if.source  blur,
	bb3_cfg_if.sink    cfg
);
	import bb3_pkg::*;

	logic [WCFG_BITS-1:0] frame_width_q;
	logic [HCFG_BITS-1:0] frame_height_q;
	logic [WCFG_BITS-1:0] eff_w;
	logic [HCFG_BITS-1:0] eff_h;
	col_t                 col_q;
	row_t                 row_q;
	logic                 last_col;
	logic                 last_row;
	logic                 accept;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 out_valid_q;
	logic                 rdy_out;
	logic                 rdy2;
	logic                 adv1;
	logic                 adv2;
	px_ctrl_t             ctrl_d;
	px_ctrl_t             ctrl_s1;
	sample_t              sample_s1;
	logic                 frame_end_s2;
	sample_t              top_rd;
	sample_t              mid_rd;
	sum_t                 sum_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg.data[WCFG_BITS-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg.data[HCFG_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < WIDTH_MIN) begin
			eff_w = WIDTH_MIN;
		end else if (frame_width_q > WIDTH_MAX) begin
			eff_w = WIDTH_MAX;
		end else begin
			eff_w = frame_width_q;
		end
		if (frame_height_q < HEIGHT_MIN) begin
			eff_h = HEIGHT_MIN;
		end else begin
			eff_h = frame_height_q;
		end
	end

	assign last_col = WCFG_BITS'(col_q) >= (eff_w - WCFG_BITS'(1));
	assign last_row = row_q >= (eff_h - HCFG_BITS'(1));

	assign ctrl_d.emit      = (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
	assign ctrl_d.frame_end = last_col && last_row;
	assign ctrl_d.col       = col_q;

	// Each stage moves on when the stage after it is empty or moving.
	assign rdy_out   = !out_valid_q || blur.ready;
	assign rdy2      = !valid_s2 || rdy_out;
	assign pix.ready = !valid_s1 || rdy2;
	assign accept    = pix.valid && pix.ready;
	assign adv1      = valid_s1 && rdy2;
	assign adv2      = valid_s2 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
				end else begin
					col_q <= col_q + COL_BITS'(1);
				end
			end
			valid_s1    <= accept || (valid_s1 && !rdy2);
			valid_s2    <= adv1 ? ctrl_s1.emit : (valid_s2 && !rdy_out);
			out_valid_q <= adv2 || (out_valid_q && !blur.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= pix.sample;
			ctrl_s1   <= ctrl_d;
		end
		if (adv1) begin
			frame_end_s2 <= ctrl_s1.frame_end;
		end
	end

	bb3_line_store u_lines (
		.clk        (clk),
		.rd_en      (accept),
		.rd_addr    (col_q),
		.sample     (pix.sample),
		.up_wr_en   (adv1),
		.up_wr_addr (ctrl_s1.col),
		.top_q      (top_rd),
		.mid_q      (mid_rd)
	);

	bb3_window_sum u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv1),
		.top    (top_rd),
		.mid    (mid_rd),
		.sample (sample_s1),
		.sum_s2 (sum_s2)
	);

	bb3_div9 u_div (
		.clk         (clk),
		.en          (adv2),
		.sum         (sum_s2),
		.frame_end   (frame_end_s2),
		.blurred_q   (blur.blurred),
		.frame_end_q (blur.frame_end)
	);

	assign blur.valid = out_valid_q;

endmodule

/* design/bb3_checker.sv */
module bb3_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input bb3_pkg::sample_t out_blurred,
	input logic             out_frame_end,
	input logic             cfg_ready
);
	import bb3_pkg::*;

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_blurred) && $stable(out_frame_end))
		else $error("result word changed while stalled");

	// The input side blocks only when every stage is full up to a stalled output.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without a stalled output");

	// An idle pipeline accepts input.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output is empty");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// The source keeps an offered word valid until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word withdrawn");

endmodule

bind box_blur_3x3_stream_core bb3_checker u_bb3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (pix.valid),
	.in_ready      (pix.ready),
	.out_valid     (blur.valid),
	.out_ready     (blur.ready),
	.out_blurred   (blur.blurred),
	.out_frame_end (blur.frame_end),
	.cfg_ready     (cfg.ready)
);
